// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers on clock; SMS_ASSERT is off in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check prop at every rising edge outside of reset.
`define SMS_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Check prop at every rising edge, reset included.
`define SMS_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== rtl/sms_pkg.sv =====
// ----------------------------------------------------------------------------
// sms_pkg
// Constants and types shared by the sorted matrix search block and its checker.
// ----------------------------------------------------------------------------
package sms_pkg;

   localparam int MAX_SIDE_DEFAULT   = 64;
   localparam int VALUE_BITS_DEFAULT = 32;

   // Register file
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int SIZE_BITS     = 7;
   localparam logic [0:0] REG_MATRIX_SIZE = 1'b0;  // register index, paddr[2]

   // Request kinds
   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_CK00  = 6'b000010,
      ST_CKMAX = 6'b000100,
      ST_ROW   = 6'b001000,
      ST_WCUR  = 6'b010000,
      ST_WDN   = 6'b100000
   } state_type;

endpackage

// ===== rtl/sorted_matrix_search.sv =====
// ----------------------------------------------------------------------------
// sorted_matrix_search
// Staircase membership search over an N-by-N matrix with nondecreasing rows
// and columns, held in one single-port synchronous memory.
// ----------------------------------------------------------------------------
// Load word: taken with busy held low; loads may come every cycle while idle.
// Query word: ends at the smallest corner if the key is at or below it, at the
//   largest if above it, else after a walk along row 0 and down the staircase.
// Result: rsp_valid pulses in the first cycle with busy low; the next word may
//   be taken in that same cycle.
// Reset: size 1, load position 0, no query in flight; matrix memory not cleared.
// ----------------------------------------------------------------------------
module sorted_matrix_search #(
   parameter int MAX_SIDE   = sms_pkg::MAX_SIDE_DEFAULT,
   parameter int VALUE_BITS = sms_pkg::VALUE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_kind,
   input  logic signed [VALUE_BITS-1:0]        req_value,
   // result channel
   output logic                                rsp_valid,
   output logic                                rsp_found,
   // register port
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [sms_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [sms_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [sms_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready
);

   // Index and address widths; keep at least one bit when MAX_SIDE is 1.
   localparam int IW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] SIDE_A = AW'(MAX_SIDE);
   localparam logic [8:0]    SIDE_9 = 9'(MAX_SIDE);

   // Clamp a size code to 1..MAX_SIDE and return the last row/column index.
   function automatic logic [IW-1:0] last_of(input logic [sms_pkg::SIZE_BITS-1:0] code);
      logic [8:0] s;
      s = {2'b00, code};
      if (s == 9'd0) begin
         s = 9'd1;
      end else if (s > SIDE_9) begin
         s = SIDE_9;
      end
      return IW'(s - 9'd1);
   endfunction

   // ------------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------------
   sms_pkg::state_type             state_ff, state_in;
   logic [sms_pkg::SIZE_BITS-1:0]  size_ff;
   logic [IW-1:0]                  row_ff, row_in;     // walk position
   logic [IW-1:0]                  col_ff, col_in;
   logic [IW-1:0]                  lrow_ff, lrow_in;   // load position
   logic [IW-1:0]                  lcol_ff, lcol_in;
   logic [VALUE_BITS-1:0]          key_ff;
   logic                           rsp_valid_ff, rsp_found_ff;

   // Matrix memory, one read or one write per cycle, read data registered.
   logic [VALUE_BITS-1:0]          mem [DEPTH];
   logic [VALUE_BITS-1:0]          rdata_ff;

   logic [IW-1:0]                  last;
   logic                           csr_wr;
   logic                           req_acc, load_acc, query_acc;
   logic                           rd_en;
   logic [IW-1:0]                  rd_row, rd_col;
   logic [AW-1:0]                  rd_addr, wr_addr;
   logic                           done, hit;
   logic                           eq, gt, lt;

   assign last      = last_of(size_ff);
   assign busy      = (state_ff != sms_pkg::ST_IDLE);
   assign req_acc   = start && !busy;
   assign load_acc  = req_acc && (req_kind == sms_pkg::KIND_LOAD);
   assign query_acc = req_acc && (req_kind == sms_pkg::KIND_QUERY);

   // Register port: one register, decoded on the word index bit.
   assign csr_wr = psel && penable && pwrite && pready
                   && (paddr[2] == sms_pkg::REG_MATRIX_SIZE);
   assign pready = 1'b1;
   always_comb begin
      prdata = '0;
      if (paddr[2] == sms_pkg::REG_MATRIX_SIZE) begin
         prdata = {{(sms_pkg::CSR_DATA_BITS - sms_pkg::SIZE_BITS){1'b0}}, size_ff};
      end
   end

   // Entry (r, c) lives at r*MAX_SIDE + c.
   assign rd_addr = AW'(rd_row) * SIDE_A + AW'(rd_col);
   assign wr_addr = AW'(lrow_ff) * SIDE_A + AW'(lcol_ff);

   // Signed compares of the entry just read against the key.
   assign eq = ($signed(rdata_ff) == $signed(key_ff));
   assign gt = ($signed(rdata_ff) >  $signed(key_ff));
   assign lt = ($signed(rdata_ff) <  $signed(key_ff));

   // ------------------------------------------------------------------------
   // Load position: rows arrive highest first, columns from 0 upward.
   // A size write rewinds to the top of the file order.
   // ------------------------------------------------------------------------
   always_comb begin
      lrow_in = lrow_ff;
      lcol_in = lcol_ff;
      if (csr_wr) begin
         lrow_in = last_of(pwdata[sms_pkg::SIZE_BITS-1:0]);
         lcol_in = '0;
      end else if (load_acc) begin
         if (lcol_ff == last) begin
            lcol_in = '0;
            lrow_in = (lrow_ff == '0) ? last : lrow_ff - 1'b1;
         end else begin
            lcol_in = lcol_ff + 1'b1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Query sequencer. Each state below consumes the entry read in the cycle
   // before and issues at most one new read.
   //   CK00 : compare against the smallest corner
   //   CKMAX: compare against the largest corner
   //   ROW  : advance right along row 0 while entries stay at or below the key
   //   WCUR : test the current entry, then probe below it (last row: step left)
   //   WDN  : the probe below is in rdata; step down or step left
   // ------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      row_in   = row_ff;
      col_in   = col_ff;
      rd_en    = 1'b0;
      rd_row   = '0;
      rd_col   = '0;
      done     = 1'b0;
      hit      = 1'b0;
      unique case (state_ff)
         sms_pkg::ST_IDLE: begin
            if (query_acc) begin
               rd_en    = 1'b1;
               state_in = sms_pkg::ST_CK00;
            end
         end
         sms_pkg::ST_CK00: begin
            if (eq) begin
               done = 1'b1;
               hit  = 1'b1;
            end else if (gt) begin
               done = 1'b1;
            end else begin
               rd_en    = 1'b1;
               rd_row   = last;
               rd_col   = last;
               state_in = sms_pkg::ST_CKMAX;
            end
         end
         sms_pkg::ST_CKMAX: begin
            if (lt) begin
               done = 1'b1;
            end else begin
               row_in = '0;
               col_in = '0;
               rd_en  = 1'b1;
               if (last != '0) begin
                  rd_col   = IW'(1);
                  state_in = sms_pkg::ST_ROW;
               end else begin
                  state_in = sms_pkg::ST_WCUR;
               end
            end
         end
         sms_pkg::ST_ROW: begin
            rd_en = 1'b1;
            if (!gt) begin
               // entry right of col is at or below the key: advance
               col_in = col_ff + 1'b1;
               if ((col_ff + 1'b1) < last) begin
                  rd_col = col_ff + IW'(2);
               end else begin
                  rd_col   = col_ff + 1'b1;
                  state_in = sms_pkg::ST_WCUR;
               end
            end else begin
               rd_col   = col_ff;
               state_in = sms_pkg::ST_WCUR;
            end
         end
         sms_pkg::ST_WCUR: begin
            if (eq) begin
               done = 1'b1;
               hit  = 1'b1;
            end else if (row_ff == last) begin
               if (col_ff == '0) begin
                  done = 1'b1;
               end else begin
                  col_in = col_ff - 1'b1;
                  rd_en  = 1'b1;
                  rd_row = row_ff;
                  rd_col = col_ff - 1'b1;
               end
            end else begin
               rd_en    = 1'b1;
               rd_row   = row_ff + 1'b1;
               rd_col   = col_ff;
               state_in = sms_pkg::ST_WDN;
            end
         end
         sms_pkg::ST_WDN: begin
            if (gt) begin
               // entry below exceeds the key: step left on this row
               if (col_ff == '0) begin
                  done = 1'b1;
               end else begin
                  col_in   = col_ff - 1'b1;
                  rd_en    = 1'b1;
                  rd_row   = row_ff;
                  rd_col   = col_ff - 1'b1;
                  state_in = sms_pkg::ST_WCUR;
               end
            end else begin
               // step down; the entry below becomes the current one
               row_in = row_ff + 1'b1;
               if (eq) begin
                  done = 1'b1;
                  hit  = 1'b1;
               end else if ((row_ff + 1'b1) == last) begin
                  if (col_ff == '0) begin
                     done = 1'b1;
                  end else begin
                     col_in   = col_ff - 1'b1;
                     rd_en    = 1'b1;
                     rd_row   = row_ff + 1'b1;
                     rd_col   = col_ff - 1'b1;
                     state_in = sms_pkg::ST_WCUR;
                  end
               end else begin
                  rd_en  = 1'b1;
                  rd_row = row_ff + IW'(2);
                  rd_col = col_ff;
               end
            end
         end
         default: begin
            state_in = sms_pkg::ST_IDLE;
         end
      endcase
      if (done) begin
         state_in = sms_pkg::ST_IDLE;
      end
   end

   // ------------------------------------------------------------------------
   // Matrix memory: loads write only while idle, reads only during a query,
   // so the single port never sees both in one cycle.
   // ------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (load_acc) begin
         mem[wr_addr] <= req_value;
      end else if (rd_en) begin
         rdata_ff <= mem[rd_addr];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sms_pkg::ST_IDLE;
         size_ff      <= sms_pkg::SIZE_BITS'(1);
         lrow_ff      <= '0;
         lcol_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lrow_ff      <= lrow_in;
         lcol_ff      <= lcol_in;
         rsp_valid_ff <= done;
         if (csr_wr) begin
            size_ff <= pwdata[sms_pkg::SIZE_BITS-1:0];
         end
      end
   end

   // Payload: walk position, key, result word
   always_ff @(posedge clock) begin
      row_ff       <= row_in;
      col_ff       <= col_in;
      rsp_found_ff <= hit;
      if (query_acc) begin
         key_ff <= req_value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_found = rsp_found_ff;

endmodule

// ===== rtl/sms_checker.sv =====
// ----------------------------------------------------------------------------
// sms_checker
// Port-level checks of the sorted matrix search request and result channels.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module sms_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_kind,
   input logic rsp_valid
);

   `SMS_ASSERT(a_rsp_when_idle, rsp_valid |-> !busy, "result word while busy")
   `SMS_ASSERT(a_query_busy, (start && !busy && (req_kind == sms_pkg::KIND_QUERY)) |=> busy, "query not taken up")
   `SMS_ASSERT(a_load_silent, (start && !busy && (req_kind == sms_pkg::KIND_LOAD)) |=> (!busy && !rsp_valid), "load word disturbed channel")
   `SMS_ASSERT(a_done_rsp, ($fell(busy) && !$past(reset)) |-> rsp_valid, "query ended without result word")
   `SMS_ASSERT_ALWAYS(a_reset_idle, reset |=> (!busy && !rsp_valid), "not idle after reset")

endmodule

bind sorted_matrix_search sms_checker u_sms_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_kind  (req_kind),
   .rsp_valid (rsp_valid)
);
